### rtl/core/bed_pkg.sv
// shared state codes, event codes and register indexes for the button event detector
package bed_pkg;

    localparam int unsigned StateW = 4;
    localparam int unsigned EventW = 4;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW = 16;
    localparam int unsigned TimeW = 32;
    localparam int unsigned CountW = 8;

    typedef logic [StateW-1:0] state_t;
    typedef logic [EventW-1:0] event_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    typedef logic [CfgW-1:0] cfg_val_t;
    typedef logic [TimeW-1:0] time_t;
    typedef logic [CountW-1:0] count_t;

    localparam state_t ST_IDLE         = 4'd0;
    localparam state_t ST_PRESS        = 4'd1;
    localparam state_t ST_WAIT_HOLD    = 4'd2;
    localparam state_t ST_CLICK        = 4'd3;
    localparam state_t ST_RELEASE      = 4'd4;
    localparam state_t ST_RELEASE_HOLD = 4'd5;
    localparam state_t ST_RELEASE_STEP = 4'd6;
    localparam state_t ST_HOLD         = 4'd7;
    localparam state_t ST_WAIT_STEP    = 4'd8;
    localparam state_t ST_STEP         = 4'd9;

    localparam event_t EV_NONE     = 4'd0;
    localparam event_t EV_PRESS    = 4'd1;
    localparam event_t EV_CLICK    = 4'd2;
    localparam event_t EV_DOUBLE   = 4'd3;
    localparam event_t EV_MULTI    = 4'd4;
    localparam event_t EV_HOLD     = 4'd5;
    localparam event_t EV_LONG     = 4'd6;
    localparam event_t EV_STEP     = 4'd7;
    localparam event_t EV_RELEASE  = 4'd8;
    localparam event_t EV_REL_STEP = 4'd9;

    localparam cfg_idx_t CFG_DEBOUNCE  = 3'd0;
    localparam cfg_idx_t CFG_CLICK_TO  = 3'd1;
    localparam cfg_idx_t CFG_HOLD      = 3'd2;
    localparam cfg_idx_t CFG_LONG_HOLD = 3'd3;
    localparam cfg_idx_t CFG_STEP      = 3'd4;

    localparam cfg_val_t DEBOUNCE_RST  = 16'd50;
    localparam cfg_val_t CLICK_TO_RST  = 16'd500;
    localparam cfg_val_t HOLD_RST      = 16'd600;
    localparam cfg_val_t LONG_HOLD_RST = 16'd1200;
    localparam cfg_val_t STEP_RST      = 16'd100;

    localparam count_t COUNT_MAX = 8'd255;

endpackage

### rtl/core/button_event_detector_unit.sv
// top level of the debounced button click, hold and step detector
//
// usage: every poll tick is one input word (pin_level, now_time) on the
// in_valid / in_stall channel; each tick gives exactly one output word
// (event_code, event_fired, click_count, held_for, is_down) on the
// out_valid / out_stall channel, in order.
// the input register holds an accepted word until the tick logic advances;
// then its result is loaded into the result register that drives the outputs.
// throughput: one word per cycle while out_stall is low; the tick logic is a
// single pass of compares and 32-bit subtractions between the two registers.
// when the receiver stalls, the result register holds its word and the input
// register can still take one more word; in_stall rises only when both are full.
// the five thresholds are written on the cfg channel (cfg_ready is always
// high) by the user only while no tick is in flight; the block does not enforce it.
// reset: all detector state clears, thresholds return to 50, 500, 600, 1200
// and 100 ms, and both pipeline registers are empty.
module button_event_detector_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              pin_level,
    input  bed_pkg::time_t    now_time,
    output logic              out_valid,
    input  logic              out_stall,
    output bed_pkg::event_t   event_code,
    output logic              event_fired,
    output bed_pkg::count_t   click_count,
    output bed_pkg::time_t    held_for,
    output logic              is_down,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bed_pkg::cfg_idx_t cfg_index,
    input  bed_pkg::cfg_val_t cfg_data
);
    import bed_pkg::*;

    // thresholds
    cfg_val_t debounce_reg;
    cfg_val_t click_to_reg;
    cfg_val_t hold_reg;
    cfg_val_t long_hold_reg;
    cfg_val_t step_reg;

    // input register
    logic  in_valid_reg;
    logic  pin_reg;
    time_t now_reg;

    // detector state
    state_t state_reg, state_next;
    logic   level_reg, level_next;
    time_t  db_start_reg, db_start_next;
    time_t  step_timer_reg, step_timer_next;
    time_t  press_time_reg, press_time_next;
    time_t  release_time_reg, release_time_next;
    count_t clicks_reg, clicks_next;
    logic   stepping_reg, stepping_next;
    logic   long_fired_reg, long_fired_next;
    time_t  hold_len_reg, hold_len_next;

    // result register
    logic   out_valid_reg;
    event_t ev_reg;
    count_t count_reg;
    time_t  held_reg;
    logic   down_reg;

    event_t ev;
    logic   done;
    state_t st_base;
    count_t clicks_inc;
    time_t  db_elapsed;
    time_t  dur;
    time_t  since_release;
    time_t  since_step;
    logic   advance;
    logic   load_in;

    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign load_in  = in_valid & ~in_stall;
    assign in_stall = in_valid_reg & out_valid_reg & out_stall;

    assign cfg_ready = 1'b1;

    assign db_elapsed    = now_reg - db_start_reg;
    assign dur           = now_reg - press_time_reg;
    assign since_release = now_reg - release_time_reg;
    assign since_step    = now_reg - step_timer_reg;
    assign clicks_inc    = (clicks_reg == COUNT_MAX) ? COUNT_MAX : clicks_reg + 8'd1;

    // one-shot states fall back at the start of the tick
    always_comb
    begin
        case (state_reg)
            ST_PRESS:        st_base = ST_WAIT_HOLD;
            ST_CLICK:        st_base = ST_IDLE;
            ST_RELEASE:      st_base = ST_IDLE;
            ST_RELEASE_HOLD: st_base = ST_IDLE;
            ST_RELEASE_STEP: st_base = ST_IDLE;
            ST_HOLD:         st_base = ST_WAIT_STEP;
            ST_STEP:         st_base = ST_WAIT_STEP;
            default:         st_base = state_reg;
        endcase
    end

    always_comb
    begin
        state_next        = st_base;
        level_next        = level_reg;
        db_start_next     = db_start_reg;
        step_timer_next   = step_timer_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        clicks_next       = clicks_reg;
        stepping_next     = stepping_reg;
        long_fired_next   = long_fired_reg;
        hold_len_next     = hold_len_reg;
        ev                = EV_NONE;
        done              = 1'b0;

        if (pin_reg != level_reg)
        begin
            if (db_start_reg == '0)
            begin
                db_start_next = now_reg;
            end
            else if (db_elapsed >= {16'd0, debounce_reg})
            begin
                level_next    = pin_reg;
                db_start_next = '0;
                done          = 1'b1;
                if (pin_reg)
                begin
                    state_next      = ST_PRESS;
                    step_timer_next = now_reg;
                    press_time_next = now_reg;
                    stepping_next   = 1'b0;
                    long_fired_next = 1'b0;
                    hold_len_next   = '0;
                    ev              = EV_PRESS;
                end
                else
                begin
                    hold_len_next = dur;
                    if (stepping_reg)
                    begin
                        state_next  = ST_RELEASE_STEP;
                        clicks_next = '0;
                        ev          = EV_REL_STEP;
                    end
                    else if (st_base == ST_WAIT_STEP)
                    begin
                        state_next  = ST_RELEASE_HOLD;
                        clicks_next = '0;
                        ev          = EV_RELEASE;
                    end
                    else if (st_base == ST_WAIT_HOLD)
                    begin
                        clicks_next       = clicks_inc;
                        release_time_next = now_reg;
                        state_next        = ST_CLICK;
                        if (clicks_inc == 8'd1)
                            ev = EV_CLICK;
                        else if (clicks_inc == 8'd2)
                            ev = EV_DOUBLE;
                        else
                            ev = EV_MULTI;
                    end
                    else
                    begin
                        state_next = ST_RELEASE;
                        ev         = EV_RELEASE;
                    end
                end
            end
        end
        else
        begin
            db_start_next = '0;
        end

        if (!done)
        begin
            if (!level_reg && clicks_reg != '0 && since_release >= {16'd0, click_to_reg})
                clicks_next = '0;

            if (level_reg)
            begin
                hold_len_next = dur;
                if (st_base == ST_WAIT_HOLD)
                begin
                    if (dur >= {16'd0, hold_reg})
                    begin
                        state_next      = ST_HOLD;
                        step_timer_next = now_reg;
                        clicks_next     = '0;
                        ev              = EV_HOLD;
                    end
                end
                else if (st_base == ST_WAIT_STEP)
                begin
                    // long hold wins over a step due on the same tick
                    if (!long_fired_reg && dur >= {16'd0, long_hold_reg})
                    begin
                        long_fired_next = 1'b1;
                        ev              = EV_LONG;
                    end
                    else if (since_step >= {16'd0, step_reg})
                    begin
                        state_next      = ST_STEP;
                        stepping_next   = 1'b1;
                        step_timer_next = now_reg;
                        ev              = EV_STEP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            click_to_reg  <= CLICK_TO_RST;
            hold_reg      <= HOLD_RST;
            long_hold_reg <= LONG_HOLD_RST;
            step_reg      <= STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                CFG_CLICK_TO:  click_to_reg  <= cfg_data;
                CFG_HOLD:      hold_reg      <= cfg_data;
                CFG_LONG_HOLD: long_hold_reg <= cfg_data;
                CFG_STEP:      step_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load_in)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            pin_reg <= pin_level;
            now_reg <= now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            level_reg        <= 1'b0;
            db_start_reg     <= '0;
            step_timer_reg   <= '0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            clicks_reg       <= '0;
            stepping_reg     <= 1'b0;
            long_fired_reg   <= 1'b0;
            hold_len_reg     <= '0;
        end
        else if (advance)
        begin
            state_reg        <= state_next;
            level_reg        <= level_next;
            db_start_reg     <= db_start_next;
            step_timer_reg   <= step_timer_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            clicks_reg       <= clicks_next;
            stepping_reg     <= stepping_next;
            long_fired_reg   <= long_fired_next;
            hold_len_reg     <= hold_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg    <= ev;
            count_reg <= clicks_next;
            held_reg  <= hold_len_next;
            down_reg  <= level_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = ev_reg;
    assign event_fired = (ev_reg != EV_NONE);
    assign click_count = count_reg;
    assign held_for    = held_reg;
    assign is_down     = down_reg;

endmodule

### rtl/core/bed_checker.sv
// port-level checker for the button event detector and its bind
module bed_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input bed_pkg::event_t   event_code,
    input logic              event_fired,
    input logic              is_down
);
    import bed_pkg::*;

    // a stalled word stays on the port
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_hold_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(event_code))
        else $error("stalled event code changed");

    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_fired == (event_code != EV_NONE)))
        else $error("fired flag disagrees with event code");

    // press and release events must agree with the debounced level
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_code != EV_PRESS || is_down)
            && ((event_code != EV_RELEASE && event_code != EV_REL_STEP
                 && event_code != EV_CLICK && event_code != EV_DOUBLE
                 && event_code != EV_MULTI) || !is_down)))
        else $error("event disagrees with debounced level");

endmodule

bind button_event_detector_unit bed_checker u_bed_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .event_fired (event_fired),
    .is_down     (is_down)
);
